### hdl/whc_pkg.sv
// Shared types and constants for the workpiece height classifier.
package whc_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_ZERO_LEVEL   = 2'd0;
    localparam logic [1:0] REG_SCALE_FACTOR = 2'd1;
    localparam logic [1:0] REG_MEASURE_EN   = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int SCALE_W    = 24;
    localparam int SCALE_FRAC = 16;
    localparam int DIFF_W     = 8;
    localparam int AVG_W      = 16;
    localparam int AVG_FRAC   = 8;
    localparam int KIND_W     = 3;

    localparam int DIFF_MAX = 127;
    localparam int DIFF_MIN = -128;

    // Height bands in millimetres
    localparam logic signed [DIFF_W-1:0] BELT_LO  = -8'sd5;
    localparam logic signed [DIFF_W-1:0] BELT_HI  = 8'sd5;
    localparam logic signed [DIFF_W-1:0] DRILL_LO = 8'sd6;
    localparam logic signed [DIFF_W-1:0] DRILL_HI = 8'sd10;
    localparam logic signed [DIFF_W-1:0] FLAT_LO  = 8'sd19;
    localparam logic signed [DIFF_W-1:0] FLAT_HI  = 8'sd23;
    localparam logic signed [DIFF_W-1:0] HIGH_LO  = 8'sd24;
    localparam logic signed [DIFF_W-1:0] HIGH_HI  = 8'sd26;

    // Result queue sizing
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = 3;
    localparam int CNT_W      = 4;

    typedef enum logic [1:0] {
        EV_REPORT  = 2'd0,
        EV_BELT    = 2'd1,
        EV_ARRIVED = 2'd2
    } ev_t;

    typedef enum logic [1:0] {
        KIND_FLAT  = 2'd0,
        KIND_HIGH  = 2'd1,
        KIND_DRILL = 2'd2,
        KIND_CODE  = 2'd3
    } ptype_t;

    // Stored kind: no piece, otherwise piece type plus one
    localparam logic [KIND_W-1:0] PIECE_NONE = 3'd0;

    typedef struct packed {
        ev_t                       event_code;
        ptype_t                    piece_type;
        logic signed [DIFF_W-1:0]  height_mm;
        logic                      last;
    } result_t;

    function automatic logic [KIND_W-1:0] kind_of(input ptype_t ty);
        kind_of = KIND_W'(ty) + KIND_W'(1);
    endfunction

endpackage

### hdl/whc_diff.sv
// Sample to rounded, saturated millimetre difference from the empty belt.
module whc_diff #(
    parameter int ADC_BITS = 12
) (
    input  logic [ADC_BITS-1:0]                  zero_level,
    input  logic [whc_pkg::SCALE_W-1:0]          scale_factor,
    input  logic [ADC_BITS-1:0]                  sample,
    output logic signed [whc_pkg::DIFF_W-1:0]    diff
);
    import whc_pkg::*;

    localparam int DW = ADC_BITS + 1;
    localparam int PW = DW + SCALE_W + 1;
    localparam int QW = PW - SCALE_FRAC;
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) <<< (SCALE_FRAC - 1);
    localparam logic signed [QW-1:0] Q_MAX = QW'(DIFF_MAX);
    localparam logic signed [QW-1:0] Q_MIN = QW'(DIFF_MIN);

    logic signed [DW-1:0]        delta;
    logic signed [SCALE_W:0]     scale_s;
    logic signed [PW-1:0]        prod;
    logic signed [PW-1:0]        rounded;
    logic signed [QW-1:0]        q;

    // Form the count difference and scale it to Q.16 millimetres
    assign delta   = $signed({1'b0, zero_level}) - $signed({1'b0, sample});
    assign scale_s = $signed({1'b0, scale_factor});
    assign prod    = PW'(delta) * PW'(scale_s);

    // Round half up, then floor by dropping the fraction
    assign rounded = prod + ROUND_HALF;
    assign q       = $signed(rounded[PW-1:SCALE_FRAC]);

    // Clamp to the signed 8-bit range
    always_comb
    begin
        if (q > Q_MAX)
        begin
            diff = DIFF_W'(DIFF_MAX);
        end
        else if (q < Q_MIN)
        begin
            diff = DIFF_W'(DIFF_MIN);
        end
        else
        begin
            diff = q[DIFF_W-1:0];
        end
    end

endmodule

### hdl/whc_track.sv
// Piece tracking state, height averaging and result generation.
module whc_track (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  logic signed [whc_pkg::DIFF_W-1:0] diff,
    output logic [1:0]                        push_cnt,
    output whc_pkg::result_t                  res0,
    output whc_pkg::result_t                  res1
);
    import whc_pkg::*;

    logic [KIND_W-1:0]       kind_reg, kind_next;
    logic signed [AVG_W-1:0] avg_reg, avg_next;
    logic                    seen_high_reg, seen_high_next;
    logic                    seen_drill_reg, seen_drill_next;
    logic                    seen_code_reg, seen_code_next;
    logic                    slowed_reg, slowed_next;

    logic signed [AVG_W:0]   avg_sum;
    logic signed [AVG_W-1:0] avg_cur;
    logic signed [AVG_W-1:0] diff_q;
    logic signed [DIFF_W-1:0] height;
    logic                    in_belt, in_drill, in_flat, in_high;

    // Diff in Q7.8 and the halved running sum
    assign diff_q  = {diff, {AVG_FRAC{1'b0}}};
    assign avg_sum = (AVG_W+1)'(avg_reg) + (AVG_W+1)'(diff_q);
    assign avg_cur = slowed_reg ? avg_sum[AVG_W:1] : avg_reg;

    // Truncate the average toward zero for the report
    assign height = avg_cur[AVG_W-1:AVG_FRAC]
                  + DIFF_W'(avg_cur[AVG_W-1] && (avg_cur[AVG_FRAC-1:0] != '0));

    assign in_belt  = (diff >= BELT_LO)  && (diff <= BELT_HI);
    assign in_drill = (diff >= DRILL_LO) && (diff <= DRILL_HI);
    assign in_flat  = (diff >= FLAT_LO)  && (diff <= FLAT_HI);
    assign in_high  = (diff >= HIGH_LO)  && (diff <= HIGH_HI);

    // Band handling and result selection
    always_comb
    begin
        kind_next       = kind_reg;
        avg_next        = avg_reg;
        seen_high_next  = seen_high_reg;
        seen_drill_next = seen_drill_reg;
        seen_code_next  = seen_code_reg;
        slowed_next     = slowed_reg;
        push_cnt        = 2'd0;
        res0            = '0;
        res1            = '0;

        if (item_valid)
        begin
            avg_next = avg_cur;
            if (in_belt)
            begin
                if (kind_reg != PIECE_NONE)
                begin
                    res0.event_code = EV_REPORT;
                    res0.piece_type = ptype_t'(2'(kind_reg - KIND_W'(1)));
                    res0.height_mm  = height;
                    res0.last       = 1'b0;
                    res1.event_code = EV_BELT;
                    res1.last       = 1'b1;
                    push_cnt        = 2'd2;
                    kind_next       = PIECE_NONE;
                    avg_next        = '0;
                    seen_high_next  = 1'b0;
                    seen_drill_next = 1'b0;
                    seen_code_next  = 1'b0;
                    slowed_next     = 1'b0;
                end
            end
            else if (in_drill)
            begin
                if (seen_high_reg)
                begin
                    seen_drill_next = 1'b1;
                end
            end
            else if (in_flat)
            begin
                if (seen_high_reg)
                begin
                    kind_next      = kind_of(KIND_CODE);
                    seen_code_next = 1'b1;
                end
                else
                begin
                    if (!slowed_reg)
                    begin
                        res0.event_code = EV_ARRIVED;
                        res0.last       = 1'b1;
                        push_cnt        = 2'd1;
                        slowed_next     = 1'b1;
                        avg_next        = diff_q;
                    end
                    kind_next = kind_of(KIND_FLAT);
                end
            end
            else if (in_high)
            begin
                if (seen_drill_reg)
                begin
                    kind_next = kind_of(KIND_DRILL);
                end
                else if (!seen_code_reg)
                begin
                    if (!slowed_reg)
                    begin
                        res0.event_code = EV_ARRIVED;
                        res0.last       = 1'b1;
                        push_cnt        = 2'd1;
                        slowed_next     = 1'b1;
                        avg_next        = diff_q;
                    end
                    seen_high_next = 1'b1;
                    kind_next      = kind_of(KIND_HIGH);
                end
            end
        end
    end

    // Hold tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= PIECE_NONE;
            avg_reg        <= '0;
            seen_high_reg  <= 1'b0;
            seen_drill_reg <= 1'b0;
            seen_code_reg  <= 1'b0;
            slowed_reg     <= 1'b0;
        end
        else
        begin
            kind_reg       <= kind_next;
            avg_reg        <= avg_next;
            seen_high_reg  <= seen_high_next;
            seen_drill_reg <= seen_drill_next;
            seen_code_reg  <= seen_code_next;
            slowed_reg     <= slowed_next;
        end
    end

    // A tracked piece always has averaging running
    a_kind_slowed: assert property (@(posedge clk) disable iff (!rst_n)
        (kind_reg != PIECE_NONE) |-> slowed_reg)
        else $error("piece tracked without averaging");

    a_drill_high: assert property (@(posedge clk) disable iff (!rst_n)
        seen_drill_reg |-> seen_high_reg)
        else $error("drill flag without high flag");

    a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt == 2'd2) |=> (kind_reg == PIECE_NONE) && !slowed_reg
                               && (avg_reg == '0))
        else $error("state not cleared after report");

endmodule

### hdl/whc_result_fifo.sv
// Result queue taking up to two results per cycle and giving one.
module whc_result_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [1:0]                  push_cnt,
    input  whc_pkg::result_t            wr_data0,
    input  whc_pkg::result_t            wr_data1,
    input  logic                        pop,
    output whc_pkg::result_t            rd_data,
    output logic [whc_pkg::CNT_W-1:0]   count,
    output logic                        not_empty
);
    import whc_pkg::*;

    result_t            entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_1;

    assign wr_ptr_1  = wr_ptr_reg + PTR_W'(1);
    assign rd_data   = entry_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign not_empty = (count_reg != '0);

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed results
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= wr_data0;
        end
        if (push_cnt == 2'd2)
        begin
            entry_reg[wr_ptr_1] <= wr_data1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ((CNT_W+1)'(count_reg) + (CNT_W+1)'(push_cnt))
            <= ((CNT_W+1)'(FIFO_DEPTH) + (CNT_W+1)'(pop)))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("result queue underflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

endmodule

### hdl/workpiece_height_classifier.sv
// Top level of the workpiece height classifier.
// An accepted sample is held in the input register, evaluated from there,
// and its results go into the eight-entry result queue that drives the output.
// Throughput: one sample per cycle unless in_stall; a report gives two
// results, leaving one per cycle unless out_stall; the queue throttles input.
// Reset clears configuration, tracking state and the queue; no clearing pass.
module workpiece_height_classifier #(
    parameter int ADC_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [whc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [whc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ADC_BITS-1:0]                 sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          event_code,
    output logic [1:0]                          piece_type,
    output logic signed [whc_pkg::DIFF_W-1:0]   height_mm,
    output logic                                last
);
    import whc_pkg::*;

    logic [ADC_BITS-1:0]      zero_reg;
    logic [SCALE_W-1:0]       scale_reg;
    logic                     enable_reg;
    logic                     in_valid_reg;
    logic [ADC_BITS-1:0]      sample_reg;
    logic                     in_accept;
    logic signed [DIFF_W-1:0] diff;
    logic [1:0]               push_cnt;
    result_t                  res0;
    result_t                  res1;
    result_t                  head;
    logic [CNT_W-1:0]         fill;
    logic [CNT_W:0]           fill_bound;
    logic                     pop;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg   <= '0;
            scale_reg  <= '0;
            enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ZERO_LEVEL:   zero_reg   <= cfg_data[ADC_BITS-1:0];
                REG_SCALE_FACTOR: scale_reg  <= cfg_data[SCALE_W-1:0];
                REG_MEASURE_EN:   enable_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Stall while the queue could not take two results from each item in flight
    assign fill_bound = (CNT_W+1)'(fill) + (CNT_W+1)'({in_valid_reg, 1'b0});
    assign in_stall   = (fill_bound > (CNT_W+1)'(FIFO_DEPTH - 2));
    assign in_accept  = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= sample;
        end
    end

    whc_diff #(
        .ADC_BITS (ADC_BITS)
    ) u_diff (
        .zero_level   (zero_reg),
        .scale_factor (scale_reg),
        .sample       (sample_reg),
        .diff         (diff)
    );

    whc_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg && enable_reg),
        .diff       (diff),
        .push_cnt   (push_cnt),
        .res0       (res0),
        .res1       (res1)
    );

    assign pop = out_valid && !out_stall;

    whc_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .wr_data0  (res0),
        .wr_data1  (res1),
        .pop       (pop),
        .rd_data   (head),
        .count     (fill),
        .not_empty (out_valid)
    );

    // Drive result transaction fields from the queue head
    assign event_code = head.event_code;
    assign piece_type = head.piece_type;
    assign height_mm  = head.height_mm;
    assign last       = head.last;

endmodule
